@@ rtl/slx_pkg.sv @@
// Shared types and constants for the s-expression token lexer.
package slx_pkg;

  typedef enum logic [3:0] {
    TK_NUM    = 4'd0,
    TK_OPEN   = 4'd1,
    TK_CLOSE  = 4'd2,
    TK_ADD    = 4'd3,
    TK_SUB    = 4'd4,
    TK_DIV    = 4'd5,
    TK_MUL    = 4'd6,
    TK_SWITCH = 4'd7,
    TK_CASE   = 4'd8,
    TK_LAMBDA = 4'd9,
    TK_IF     = 4'd10,
    TK_WHILE  = 4'd11,
    TK_END    = 4'd12,
    TK_ERROR  = 4'd13
  } token_kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_NUM  = 4'b0010,
    MODE_WORD = 4'b0100,
    MODE_ERR  = 4'b1000
  } scan_mode_e;

  localparam int unsigned VALUE_W = 31;
  localparam logic [VALUE_W-1:0] NUM_MAX = '1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam int unsigned NUM_KW     = 5;
  localparam int unsigned KW_MAX_LEN = 6;

  // byte j of a keyword sits at bits [8*j +: 8]
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
    48'h0000_0000_6669,
    48'h0065_6C69_6877,
    48'h6164_626D_616C,
    48'h6863_7469_7773,
    48'h0000_6573_6163
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd5, 3'd6, 3'd6, 3'd4};
  localparam token_kind_e KW_KIND [NUM_KW] = '{TK_IF, TK_WHILE, TK_LAMBDA, TK_SWITCH, TK_CASE};

  typedef struct packed {
    token_kind_e        kind;
    logic [VALUE_W-1:0] value;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

@@ rtl/slx_front.sv @@
// Front end: scans bytes, keeps the lexer state and forms up to two tokens per byte.
module slx_front import slx_pkg::*; #(
  parameter int unsigned KEYWORD_CHARS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output slot_t      push_o
);

  localparam int unsigned LEN_W = $clog2(KEYWORD_CHARS + 1);
  localparam int unsigned IDX_W = $clog2(KEYWORD_CHARS);

  scan_mode_e         mode_q, mode_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               over_q, over_d;
  logic [7:0]         chars_q [KEYWORD_CHARS];
  logic [7:0]         chars_d [KEYWORD_CHARS];

  logic               is_digit, is_alpha;
  logic [VALUE_W+3:0] acc_prod;
  logic [VALUE_W-1:0] acc_next;
  token_kind_e        word_kind;
  logic [NUM_KW-1:0]  kw_hit;
  logic               flush_v, fresh_v, do_fresh;
  token_t             flush_tok, fresh_tok;

  assign is_digit = text_byte_i inside {[CH_0:CH_9]};
  assign is_alpha = text_byte_i inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};

  assign acc_prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {31'd0, text_byte_i[3:0]};
  assign acc_next = (acc_prod > {4'd0, NUM_MAX}) ? NUM_MAX : acc_prod[VALUE_W-1:0];

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      kw_hit[k] = (len_q == LEN_W'(KW_LEN[k]));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < int'(KW_LEN[k]) && chars_q[j] != KW_TEXT[k][8*j +: 8]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
    word_kind = TK_ERROR;
    if (!over_q) begin
      for (int k = NUM_KW - 1; k >= 0; k--) begin
        if (kw_hit[k]) begin
          word_kind = KW_KIND[k];
        end
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    len_d     = len_q;
    over_d    = over_q;
    chars_d   = chars_q;
    flush_v   = 1'b0;
    flush_tok = '{kind: TK_NUM, value: '0};
    fresh_v   = 1'b0;
    fresh_tok = '{kind: TK_NUM, value: '0};
    do_fresh  = 1'b0;

    if (end_of_text_i) begin
      if (mode_q == MODE_NUM) begin
        flush_v   = 1'b1;
        flush_tok = '{kind: TK_NUM, value: acc_q};
      end else if (mode_q == MODE_WORD) begin
        flush_v        = 1'b1;
        flush_tok.kind = word_kind;
      end
      fresh_v        = 1'b1;
      fresh_tok.kind = TK_END;
      mode_d         = MODE_IDLE;
      acc_d          = '0;
      len_d          = '0;
      over_d         = 1'b0;
    end else begin
      case (mode_q)
        MODE_ERR: begin
        end
        MODE_NUM: begin
          if (is_digit) begin
            acc_d = acc_next;
          end else begin
            flush_v   = 1'b1;
            flush_tok = '{kind: TK_NUM, value: acc_q};
            do_fresh  = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_digit || is_alpha) begin
            if (len_q < LEN_W'(KEYWORD_CHARS)) begin
              chars_d[len_q[IDX_W-1:0]] = text_byte_i;
              len_d                     = len_q + LEN_W'(1);
            end else begin
              over_d = 1'b1;
            end
          end else begin
            flush_v        = 1'b1;
            flush_tok.kind = word_kind;
            if (word_kind == TK_ERROR) begin
              mode_d = MODE_ERR;
            end else begin
              do_fresh = 1'b1;
            end
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase

      if (do_fresh) begin
        mode_d = MODE_IDLE;
        case (text_byte_i)
          CH_PLUS: begin
            fresh_v        = 1'b1;
            fresh_tok.kind = TK_ADD;
          end
          CH_MINUS: begin
            fresh_v        = 1'b1;
            fresh_tok.kind = TK_SUB;
          end
          CH_SLASH: begin
            fresh_v        = 1'b1;
            fresh_tok.kind = TK_DIV;
          end
          CH_STAR: begin
            fresh_v        = 1'b1;
            fresh_tok.kind = TK_MUL;
          end
          CH_LPAR: begin
            fresh_v        = 1'b1;
            fresh_tok.kind = TK_OPEN;
          end
          CH_RPAR: begin
            fresh_v        = 1'b1;
            fresh_tok.kind = TK_CLOSE;
          end
          CH_SPACE, CH_TAB, CH_LF: begin
          end
          default: begin
            if (is_digit) begin
              mode_d = MODE_NUM;
              acc_d  = {27'd0, text_byte_i[3:0]};
            end else if (is_alpha) begin
              mode_d     = MODE_WORD;
              chars_d[0] = text_byte_i;
              len_d      = LEN_W'(1);
              over_d     = 1'b0;
            end else begin
              mode_d         = MODE_ERR;
              fresh_v        = 1'b1;
              fresh_tok.kind = TK_ERROR;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push_o.valid     = accept_i && (flush_v || fresh_v);
    push_o.entry.two = flush_v && fresh_v;
    push_o.entry.t0  = flush_v ? flush_tok : fresh_tok;
    push_o.entry.t1  = fresh_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      len_q  <= '0;
      over_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      len_q  <= len_d;
      over_q <= over_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      chars_q <= chars_d;
    end
  end

endmodule

@@ rtl/slx_queue.sv @@
// Token-pair queue between the front end and the output stage.
module slx_queue import slx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  slot_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output slot_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i.valid && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!push_i.valid && pop_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("push into full token queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_o.valid))
    else $error("pop from empty token queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("token queue count out of range");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid && !pop_i |=> head_o.valid)
    else $error("pushed entry not visible");
`endif

endmodule

@@ rtl/slx_back.sv @@
// Output stage: drains queue entries one token per beat into the output register.
module slx_back import slx_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slot_t                head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           token_kind_o,
  output logic [VALUE_W-1:0]   token_value_o,
  output logic                 last_of_run_o
);

  logic   out_valid_q;
  logic   half_q;
  token_t tok_q;
  logic   last_q;
  logic   load;

  assign load  = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = load && (!head_i.entry.two || half_q);

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = tok_q.kind;
  assign token_value_o = tok_q.value;
  assign last_of_run_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      half_q      <= head_i.entry.two && !half_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= half_q ? head_i.entry.t1 : head_i.entry.t0;
      last_q <= !head_i.entry.two || half_q;
    end
  end

endmodule

@@ rtl/sexpr_token_lexer.sv @@
// Top level of the s-expression token lexer.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+----
//  in      | in_valid_i, in_ready_o, text_byte_i,            | in
//          | end_of_text_i                                   |
//  out     | out_valid_o, out_ready_i, token_kind_o,         | out
//          | token_value_o, last_of_run_o                    |
//
// One byte is taken per cycle while the token queue is not full; its tokens are written
// into the token queue and from there loaded into the output register, which sends one
// token per cycle while out_ready_i is high, so a byte that makes two tokens is sent as two.
// A two-entry token queue absorbs output stalls; in_ready_o drops when it is full.
// Reset returns the scanner to idle and empties the queue and output register.
module sexpr_token_lexer import slx_pkg::*; #(
  parameter int unsigned KEYWORD_CHARS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         token_kind_o,
  output logic [VALUE_W-1:0] token_value_o,
  output logic               last_of_run_o
);

  slot_t push;
  slot_t head;
  logic  full;
  logic  pop;
  logic  accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  slx_front #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push)
  );

  slx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  slx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
